// ===== rtl/bmpq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmpq_pkg
// Shared types and constants for the bounded min-first priority queue.
// ----------------------------------------------------------------------------
package bmpq_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int DATA_W       = 32;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_OVERFLOW  = 2'd1,
    STAT_UNDERFLOW = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/bmpq_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmpq_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bmpq_ram #(
  parameter int WIDTH  = 64,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== rtl/bounded_min_priority_queue_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_min_priority_queue_top
// Bounded priority queue of (value, priority) pairs kept in one RAM in
// insertion order; a delete returns the earliest pair of smallest priority.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------
//  input   | in        | in_valid/in_stall  | op, item_value, item_priority
//  output  | out       | out_valid/out_stall| out_value, out_priority, status
//
// An insert, an overflow and an underflow are answered straight from idle. A
// delete scans every pair in the queue through the RAM read port, then moves
// each pair behind the winner one slot down to close the gap, then hands over
// the result.
// Reset clears the fill count and the result valid flag; RAM contents are left.
// A stalled result holds the output register, and the block takes no new beat
// until that register is free.
module bounded_min_priority_queue_top import bmpq_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic                     op,
  input  wire logic signed [DATA_W-1:0] item_value,
  input  wire logic signed [DATA_W-1:0] item_priority,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic signed      [DATA_W-1:0] out_value,
  output logic signed      [DATA_W-1:0] out_priority,
  output logic             [1:0]        status
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = 2 * DATA_W;
  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE     = CW'(1);
  localparam logic [CW-1:0] TWO     = CW'(2);

  state_t state, state_next;

  logic [CW-1:0]     count;
  logic [CW-1:0]     idx;
  logic [CW-1:0]     best_idx;
  logic [CW-1:0]     best_idx_next;
  logic [DATA_W-1:0] best_val;
  logic [DATA_W-1:0] best_pri;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [EW-1:0] wr_data;
  logic [CW-1:0] rd_idx;
  logic [EW-1:0] rd_data;

  logic [DATA_W-1:0] rd_val;
  logic [DATA_W-1:0] rd_pri;
  logic              better;
  logic              last_scan;
  logic              out_free;
  logic              accept;
  logic              direct_reply;
  logic              is_insert;
  logic              is_full;
  logic              is_empty;

  assign rd_val = rd_data[EW-1:DATA_W];
  assign rd_pri = rd_data[DATA_W-1:0];

  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = rst || (state != ST_IDLE) || !out_free;
  assign accept    = in_valid && !in_stall;
  assign is_insert = (op == OP_INSERT);
  assign is_full   = (count >= CAP_CNT);
  assign is_empty  = (count == '0);

  // Inserts and failed deletes are answered at once; a delete that finds a
  // pair answers only when the scan and the shift are over.
  assign direct_reply = accept && (is_insert || is_empty);

  // The first pair seen always wins; afterwards only a strictly smaller
  // priority does, so ties go to the pair inserted earlier.
  assign better        = (idx == '0) || ($signed(rd_pri) < $signed(best_pri));
  assign best_idx_next = better ? idx : best_idx;
  assign last_scan     = (idx == count - ONE);

  bmpq_ram #(
    .WIDTH (EW),
    .DEPTH (CAPACITY),
    .ADDR_W(AW)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_idx[AW-1:0]),
    .rd_data(rd_data)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && !is_insert && !is_empty) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (last_scan) begin
          state_next = (best_idx_next + ONE == count) ? ST_DONE : ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        if (idx + TWO == count) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // RAM port control. During the shift each pair, read through the registered
  // read port, is written one slot down, so a read and a write never meet at one entry.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count[AW-1:0];
    wr_data = {item_value, item_priority};
    rd_idx  = '0;
    case (state)
      ST_IDLE: begin
        wr_en = accept && is_insert && !is_full;
      end
      ST_SCAN: begin
        rd_idx = last_scan ? (best_idx_next + ONE) : (idx + ONE);
      end
      ST_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = idx[AW-1:0];
        wr_data = rd_data;
        rd_idx  = idx + TWO;
      end
      ST_DONE: begin
        rd_idx = '0;
      end
      default: rd_idx = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      idx   <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          idx <= '0;
          if (accept && is_insert && !is_full) begin
            count <= count + ONE;
          end
        end
        ST_SCAN: begin
          idx <= last_scan ? best_idx_next : idx + ONE;
        end
        ST_SHIFT: begin
          idx <= idx + ONE;
        end
        ST_DONE: begin
          if (out_free) begin
            count <= count - ONE;
          end
        end
        default: idx <= '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_SCAN) begin
      best_idx <= best_idx_next;
      if (better) begin
        best_val <= rd_val;
        best_pri <= rd_pri;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (direct_reply || (state == ST_DONE && out_free)) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (direct_reply) begin
      out_value    <= '0;
      out_priority <= '0;
      if (is_insert) begin
        status <= is_full ? STAT_OVERFLOW : STAT_OK;
      end else begin
        status <= STAT_UNDERFLOW;
      end
    end else if (state == ST_DONE && out_free) begin
      out_value    <= best_val;
      out_priority <= best_pri;
      status       <= STAT_OK;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bmpq_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmpq_checker
// Port-level checks for the priority queue, bound to the top level.
// ----------------------------------------------------------------------------
module bmpq_checker import bmpq_pkg::*; (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire logic              op,
  input wire logic [DATA_W-1:0] out_value,
  input wire logic [DATA_W-1:0] out_priority,
  input wire logic [1:0]        status,
  input wire logic              out_valid,
  input wire logic              out_stall
);

  // A stalled result beat stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result beat withdrawn while stalled");

  // A stalled result beat keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(out_value) && $stable(out_priority)
                               && $stable(status))
    else $error("result payload changed while stalled");

  // An insert is answered in the very next cycle.
  a_insert_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && op == OP_INSERT |=> out_valid)
    else $error("insert not answered in the next cycle");

  // Failed operations carry no pair.
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STAT_OVERFLOW || status == STAT_UNDERFLOW)
      |-> out_value == '0 && out_priority == '0)
    else $error("error beat carries a pair");

  // The reserved status code never appears.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status != 2'd3)
    else $error("reserved status code on output");

endmodule

bind bounded_min_priority_queue_top bmpq_checker u_bmpq_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .op          (op),
  .out_value   (out_value),
  .out_priority(out_priority),
  .status      (status),
  .out_valid   (out_valid),
  .out_stall   (out_stall)
);

`default_nettype wire
